// ===== hw/rtl/tsfv_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfv_pkg: shared types and constants for the topological sort block
// Request codes, status codes and the item structs.
// ----------------------------------------------------------------------------
`default_nettype none
package tsfv_pkg;
  localparam int DefMaxNodes = 1024;
  localparam int DefMaxEdges = 4096;

  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_RUN   = 3'd2;
  localparam logic [2:0] REQ_ORDER = 3'd3;
  localparam logic [2:0] REQ_FB    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] from_node;
    logic [9:0] to_node;
    logic [9:0] index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  node_id;
    logic [10:0] kept_count;
    logic [10:0] feedback_count;
  } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tsfv_ram.sv =====
// ----------------------------------------------------------------------------
// tsfv_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tsfv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(Depth)-1:0]  waddr,
  input  wire [Width-1:0]          wdata,
  input  wire [$clog2(Depth)-1:0]  raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/topo_sort_feedback_vertex_top.sv =====
// ----------------------------------------------------------------------------
// topo_sort_feedback_vertex_top: DFS topological order with feedback removal
// Sequencer over edge, node and walk memories.
// ----------------------------------------------------------------------------
// Usage: drive req with start high while busy is low; the item is taken at
// that edge. Exactly one result per item appears on rsp with done high for
// one cycle; the receiver cannot stall, so the result must be sampled then.
// node_count_we/node_count_wdata write the node count; the user must write
// it only while idle, which the block itself does not enforce.
// Sequence: after reset the block sweeps node_head to null with busy high
// and gives no result. Clear repeats that sweep and then replies. Add edge
// steps through check, head read and edge write, reply; a rejected add goes
// from the check to the reply. Reads step through index check, memory read,
// reply, or from the check to the reply when the index is out of range.
// Unused request codes go straight to the reply. done is high in the first
// cycle with busy low, so a new item may be taken in the same cycle as the
// result. A run sweeps the node flags, then walks each node through root
// scan, enter, final pop, ranking and compaction, and each walked edge
// through frame read, edge read and target flag check. Each memory has a
// single read port.
// ----------------------------------------------------------------------------
`default_nettype none
module topo_sort_feedback_vertex_top
  import tsfv_pkg::*;
#(
  parameter int MaxNodes = DefMaxNodes,
  parameter int MaxEdges = DefMaxEdges
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  req_t        req,
  output logic        busy,
  output logic        done,
  output rsp_t        rsp,
  input  wire         node_count_we,
  input  wire [10:0]  node_count_wdata
);
  localparam int NW = $clog2(MaxNodes);
  localparam int EW = $clog2(MaxEdges);
  localparam int NC = NW + 1;
  localparam int EC = EW + 1;
  localparam logic [EC-1:0] NIL = EC'(MaxEdges);

  // states
  localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_ADD = 5'd2,
    S_ADD2 = 5'd3, S_READ = 5'd4, S_READ2 = 5'd5, S_RCLR = 5'd6,
    S_ROOT = 5'd7, S_ROOT2 = 5'd8, S_ENTER = 5'd9, S_TOP = 5'd10,
    S_TOP2 = 5'd11, S_EDGE = 5'd12, S_EDGE2 = 5'd13, S_TGT = 5'd14,
    S_RANK = 5'd15, S_RANK2 = 5'd16, S_CMP = 5'd17, S_CMP2 = 5'd18,
    S_CMP3 = 5'd19, S_REPLY = 5'd20, S_CMP4 = 5'd21, S_CLR = 5'd22;

  logic [4:0]  state;
  logic [10:0] node_count;
  logic [NC-1:0] n_eff;
  req_t        cur;
  logic [EC-1:0] edge_total;
  logic [NC-1:0] cnt, sp, fin_ptr, kept, fbc, rnk, kidx;
  logic [NW-1:0] root, vtx, tgt;
  logic [EC-1:0] cur_e;
  logic [1:0]  st;
  logic [NW-1:0] rid;
  logic          kept_ok;

  // memory ports
  logic we_head, we_et, we_en, we_flag, we_stk, we_ord, we_rank, we_fbl;
  logic [NW-1:0] wa_head, ra_head, wa_flag, ra_flag, wa_stk, ra_stk;
  logic [NW-1:0] wa_ord, ra_ord, wa_rank, ra_rank, wa_fbl, ra_fbl;
  logic [EW-1:0] wa_e, ra_e;
  logic [EC-1:0] wd_head, rd_head, wd_en, rd_en;
  logic [NW-1:0] wd_et, rd_et, wd_ord, rd_ord, wd_rank, rd_rank, wd_fbl, rd_fbl;
  logic [2:0]    wd_flag, rd_flag;          // {feedback, on_path, visited}
  logic [NW+EC-1:0] wd_stk, rd_stk;

  tsfv_ram #(.Width(EC), .Depth(MaxNodes)) u_head (.clk, .we(we_head),
    .waddr(wa_head), .wdata(wd_head), .raddr(ra_head), .rdata(rd_head));
  tsfv_ram #(.Width(NW), .Depth(MaxEdges)) u_etgt (.clk, .we(we_et),
    .waddr(wa_e), .wdata(wd_et), .raddr(ra_e), .rdata(rd_et));
  tsfv_ram #(.Width(EC), .Depth(MaxEdges)) u_enxt (.clk, .we(we_en),
    .waddr(wa_e), .wdata(wd_en), .raddr(ra_e), .rdata(rd_en));
  tsfv_ram #(.Width(3), .Depth(MaxNodes)) u_flag (.clk, .we(we_flag),
    .waddr(wa_flag), .wdata(wd_flag), .raddr(ra_flag), .rdata(rd_flag));
  tsfv_ram #(.Width(NW+EC), .Depth(MaxNodes)) u_stk (.clk, .we(we_stk),
    .waddr(wa_stk), .wdata(wd_stk), .raddr(ra_stk), .rdata(rd_stk));
  tsfv_ram #(.Width(NW), .Depth(MaxNodes)) u_ord (.clk, .we(we_ord),
    .waddr(wa_ord), .wdata(wd_ord), .raddr(ra_ord), .rdata(rd_ord));
  tsfv_ram #(.Width(NW), .Depth(MaxNodes)) u_rank (.clk, .we(we_rank),
    .waddr(wa_rank), .wdata(wd_rank), .raddr(ra_rank), .rdata(rd_rank));
  tsfv_ram #(.Width(NW), .Depth(MaxNodes)) u_fbl (.clk, .we(we_fbl),
    .waddr(wa_fbl), .wdata(wd_fbl), .raddr(ra_fbl), .rdata(rd_fbl));

  // effective node count: limit to MaxNodes
  always_comb begin
    if ({21'd0, node_count} > 32'(MaxNodes)) n_eff = NC'(MaxNodes);
    else n_eff = NC'(node_count);
  end

  assign busy = (state != S_IDLE);
  assign kept_ok = (NC'(tgt) < n_eff);

  // Combinational memory control; each state drives only the ports it uses.
  always_comb begin
    we_head = 1'b0; we_et = 1'b0; we_en = 1'b0; we_flag = 1'b0;
    we_stk = 1'b0; we_ord = 1'b0; we_rank = 1'b0; we_fbl = 1'b0;
    wa_head = cnt[NW-1:0]; wd_head = NIL; ra_head = cur.from_node[NW-1:0];
    wa_e = edge_total[EW-1:0]; wd_et = cur.to_node[NW-1:0]; wd_en = rd_head;
    ra_e = cur_e[EW-1:0];
    wa_flag = cnt[NW-1:0]; wd_flag = 3'b000; ra_flag = cnt[NW-1:0];
    wa_stk = sp[NW-1:0]; wd_stk = {vtx, rd_head}; ra_stk = sp[NW-1:0] - NW'(1);
    wa_ord = fin_ptr[NW-1:0] - NW'(1); wd_ord = vtx; ra_ord = cur.index[NW-1:0];
    wa_rank = cnt[NW-1:0]; wd_rank = rnk[NW-1:0]; ra_rank = rd_ord;
    wa_fbl = fbc[NW-1:0]; wd_fbl = cnt[NW-1:0]; ra_fbl = cur.index[NW-1:0];
    case (state)
      S_INIT, S_CLR: we_head = 1'b1;
      S_ADD2: begin
        we_et = 1'b1; we_en = 1'b1; we_head = 1'b1;
        wa_head = cur.from_node[NW-1:0]; wd_head = edge_total;
      end
      S_RCLR: we_flag = 1'b1;
      S_ROOT: begin
        ra_head = root; ra_flag = root;
      end
      S_ROOT2: ra_head = root;
      S_ENTER: begin
        // rd_head holds head of vtx; push the frame, mark visited+on path
        we_stk = 1'b1;
        we_flag = 1'b1; wa_flag = vtx; wd_flag = 3'b011;
      end
      S_EDGE2: begin
        ra_flag = rd_et;
        we_stk = 1'b1; wa_stk = sp[NW-1:0] - NW'(1);
        wd_stk = {vtx, rd_en};
      end
      S_TGT: begin
        ra_head = tgt;
        if (kept_ok && rd_flag[1]) begin
          we_flag = 1'b1; wa_flag = tgt; wd_flag = rd_flag | 3'b100;
        end
      end
      S_CMP4: begin
        // pop: clear on-path, keep feedback/visited
        we_flag = 1'b1; wa_flag = vtx; wd_flag = rd_flag & 3'b101;
        ra_flag = vtx;
        if (fin_ptr != '0) we_ord = 1'b1;
      end
      // read the flags of the node in the top frame
      S_TOP2: ra_flag = rd_stk[NW+EC-1:EC];
      S_RANK2: begin
        if (rd_flag[2]) we_fbl = 1'b1;
        else we_rank = 1'b1;
      end
      S_CMP2: ra_flag = rd_ord;
      S_CMP3: begin
        wa_ord = kidx[NW-1:0]; wd_ord = rd_rank;
        if (!rd_flag[2]) we_ord = 1'b1;
      end
      default: ;
    endcase
    if (state == S_CMP) ra_ord = cnt[NW-1:0];
    if (state == S_CMP2) ra_ord = cnt[NW-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; cnt <= '0; node_count <= 11'd1; edge_total <= '0;
      kept <= '0; fbc <= '0; done <= 1'b0; sp <= '0;
    end else begin
      done <= (state == S_REPLY);
      if (node_count_we) node_count <= node_count_wdata;
      case (state)
        // head sweep: after reset go idle silently, after clear reply
        S_INIT, S_CLR: begin
          if (cnt == NC'(MaxNodes - 1)) begin
            cnt <= '0; edge_total <= '0;
            state <= (state == S_CLR) ? S_REPLY : S_IDLE;
          end else cnt <= cnt + NC'(1);
        end
        S_IDLE: begin
          if (start) begin
            cur <= req; st <= ST_OK; rid <= '0; cnt <= '0;
            case (req.req_type)
              REQ_CLEAR: state <= S_CLR;
              REQ_ADD: state <= S_ADD;
              REQ_RUN: begin
                state <= S_RCLR; fin_ptr <= n_eff;
              end
              REQ_ORDER, REQ_FB: state <= S_READ;
              default: state <= S_REPLY;
            endcase
          end
        end
        S_ADD: begin
          if ({1'b0, cur.from_node} >= 11'(n_eff) ||
              {1'b0, cur.to_node} >= 11'(n_eff)) begin
            st <= ST_RANGE; state <= S_REPLY;
          end else if (edge_total >= EC'(MaxEdges)) begin
            st <= ST_FULL; state <= S_REPLY;
          end else state <= S_ADD2;
        end
        S_ADD2: begin
          edge_total <= edge_total + EC'(1); state <= S_REPLY;
        end
        S_READ: begin
          if (cur.req_type == REQ_ORDER) begin
            if ({1'b0, cur.index} >= 11'(kept)) begin
              st <= ST_INDEX; state <= S_REPLY;
            end else state <= S_READ2;
          end else begin
            if ({1'b0, cur.index} >= 11'(fbc)) begin
              st <= ST_INDEX; state <= S_REPLY;
            end else state <= S_READ2;
          end
        end
        S_READ2: begin
          rid <= (cur.req_type == REQ_ORDER) ? rd_ord : rd_fbl;
          state <= S_REPLY;
        end
        S_RCLR: begin
          if (cnt == NC'(MaxNodes - 1)) begin
            cnt <= '0; root <= '0;
            if (n_eff == '0) state <= S_RANK;
            else state <= S_ROOT;
          end else cnt <= cnt + NC'(1);
          if (cnt == '0) begin
            kept <= '0; fbc <= '0; rnk <= '0;
          end
        end
        // root scan: read flags and head of root
        S_ROOT: begin
          cnt <= NC'(root); state <= S_ROOT2;
        end
        S_ROOT2: begin
          // rd_flag for root valid now (read at root)
          if (rd_flag[0]) begin
            if (NC'(root) + NC'(1) >= n_eff) begin
              cnt <= '0; state <= S_RANK;
            end else begin
              root <= root + NW'(1); state <= S_ROOT;
            end
          end else begin
            vtx <= root; sp <= '0; state <= S_ENTER;
          end
        end
        S_ENTER: begin
          sp <= sp + NC'(1); state <= S_TOP;
        end
        S_TOP: state <= S_TOP2;          // stack read of top frame
        S_TOP2: begin
          vtx <= rd_stk[NW+EC-1:EC]; cur_e <= rd_stk[EC-1:0];
          if (rd_stk[EC-1:0] < EC'(MaxEdges)) state <= S_EDGE;
          else state <= S_CMP4;
        end
        S_EDGE: state <= S_EDGE2;        // edge memories read
        S_EDGE2: begin
          tgt <= rd_et; state <= S_TGT;
        end
        S_TGT: begin
          // rd_flag of tgt valid; rd_head of tgt valid next cycle
          if (kept_ok && !rd_flag[1] && !rd_flag[0] && sp < NC'(MaxNodes)) begin
            vtx <= tgt; state <= S_ENTER;
          end else state <= S_TOP;
        end
        S_CMP4: begin
          if (fin_ptr != '0) fin_ptr <= fin_ptr - NC'(1);
          sp <= sp - NC'(1);
          if (sp == NC'(1)) begin
            if (NC'(root) + NC'(1) >= n_eff) begin
              cnt <= '0; state <= S_RANK;
            end else begin
              root <= root + NW'(1); state <= S_ROOT;
            end
          end else state <= S_TOP;
        end
        // ranking pass over node ids
        S_RANK: begin
          if (cnt >= n_eff) begin
            cnt <= '0; kidx <= '0; state <= S_CMP;
          end else state <= S_RANK2;
        end
        S_RANK2: begin
          if (rd_flag[2]) fbc <= fbc + NC'(1);
          else rnk <= rnk + NC'(1);
          cnt <= cnt + NC'(1); state <= S_RANK;
        end
        // compaction pass over the finish order
        S_CMP: begin
          if (cnt >= n_eff) begin
            kept <= kidx; state <= S_REPLY;
          end else state <= S_CMP2;
        end
        S_CMP2: state <= S_CMP3;
        S_CMP3: begin
          if (!rd_flag[2]) kidx <= kidx + NC'(1);
          cnt <= cnt + NC'(1); state <= S_CMP;
        end
        S_REPLY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.status = st;
    rsp.node_id = 10'(rid);
    rsp.kept_count = 11'(kept);
    rsp.feedback_count = 11'(fbc);
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result outside idle");
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= NC'(MaxNodes)) else $error("stack overflow");
  a_kept_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (kept + fbc) <= NC'(MaxNodes)) else $error("counts exceed nodes");
endmodule
`default_nettype wire

// ===== test/tb_topo_sort_feedback_vertex_top.sv =====
// ----------------------------------------------------------------------------
// tb_topo_sort_feedback_vertex_top: self-checking bench for the DFS sort block
// Loads random graphs, runs sorts, reads order and feedback lists, and checks
// every result against a behavioral model of the walk kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_topo_sort_feedback_vertex_top;
  import tsfv_pkg::*;

  localparam int NodeMax  = DefMaxNodes;
  localparam int EdgeMax  = DefMaxEdges;
  localparam int CycleCap = 3000000;

  logic        clk;
  logic        rst;
  logic        start;
  req_t        req;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic        node_count_we;
  logic [10:0] node_count_wdata;

  topo_sort_feedback_vertex_top DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .req              (req),
    .busy             (busy),
    .done             (done),
    .rsp              (rsp),
    .node_count_we    (node_count_we),
    .node_count_wdata (node_count_wdata)
  );

  // Model state: edge store, node heads, last-run lists.
  int unsigned m_target [EdgeMax];
  int unsigned m_next   [EdgeMax];
  int unsigned m_head   [NodeMax];
  int unsigned m_edges;
  int unsigned m_nodes;
  int unsigned m_order  [NodeMax];
  int unsigned m_rank   [NodeMax];
  int unsigned m_fbl    [NodeMax];
  bit          m_seen   [NodeMax];
  bit          m_path   [NodeMax];
  bit          m_fb     [NodeMax];
  int unsigned m_snode  [NodeMax];
  int unsigned m_scur   [NodeMax];
  int unsigned m_kept;
  int unsigned m_fbcnt;

  rsp_t        expected_rsp[$];
  int          errors;
  int          n_items;
  int          n_results;
  int          n_runs;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned eff_nodes();
    return (m_nodes > NodeMax) ? NodeMax : m_nodes;
  endfunction

  function automatic void model_clear();
    for (int v = 0; v < NodeMax; v++) m_head[v] = EdgeMax;
    m_edges = 0;
  endfunction

  // Walk depth-first from each unvisited root; fill order from the back.
  function automatic void model_sort();
    int unsigned n, sp, fin, e, t, v, r, fc, k;
    n = eff_nodes();
    for (int i = 0; i < NodeMax; i++) begin
      m_seen[i] = 0; m_path[i] = 0; m_fb[i] = 0;
    end
    fin = n;
    for (int unsigned root = 0; root < n; root++) begin
      if (m_seen[root]) continue;
      sp = 0;
      m_seen[root] = 1; m_path[root] = 1;
      m_snode[0] = root; m_scur[0] = m_head[root]; sp = 1;
      while (sp > 0) begin
        e = m_scur[sp-1];
        if (e < EdgeMax) begin
          t = m_target[e];
          m_scur[sp-1] = m_next[e];
          if (t >= n) continue;
          if (m_path[t]) m_fb[t] = 1;
          else if (!m_seen[t] && sp < NodeMax) begin
            m_seen[t] = 1; m_path[t] = 1;
            m_snode[sp] = t; m_scur[sp] = m_head[t]; sp++;
          end
        end else begin
          v = m_snode[sp-1];
          m_path[v] = 0;
          sp--;
          if (fin > 0) begin
            fin--;
            m_order[fin] = v;
          end
        end
      end
    end
    r = 0; fc = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (m_fb[i]) m_fbl[fc++] = i;
      else m_rank[i] = r++;
    end
    k = 0;
    for (int unsigned p = 0; p < n; p++) begin
      v = m_order[p];
      if (v < NodeMax && !m_fb[v]) m_order[k++] = m_rank[v];
    end
    m_kept = k;
    m_fbcnt = fc;
  endfunction

  // Predict the one result an item causes and advance the model.
  function automatic rsp_t predict_rsp(req_t it);
    rsp_t r;
    int unsigned n;
    n = eff_nodes();
    r = '0;
    case (it.req_type)
      REQ_CLEAR: model_clear();
      REQ_ADD: begin
        if (it.from_node >= n || it.to_node >= n) r.status = ST_RANGE;
        else if (m_edges >= EdgeMax) r.status = ST_FULL;
        else begin
          m_target[m_edges] = it.to_node;
          m_next[m_edges]   = m_head[it.from_node];
          m_head[it.from_node] = m_edges;
          m_edges++;
        end
      end
      REQ_RUN: begin
        model_sort();
        n_runs++;
      end
      REQ_ORDER: begin
        if (it.index < m_kept) r.node_id = 10'(m_order[it.index]);
        else r.status = ST_INDEX;
      end
      REQ_FB: begin
        if (it.index < m_fbcnt) r.node_id = 10'(m_fbl[it.index]);
        else r.status = ST_INDEX;
      end
      default: ;
    endcase
    r.kept_count     = m_kept[10:0];
    r.feedback_count = m_fbcnt[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Compare every strobed result with the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      n_results++;
      if (expected_rsp.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
        if (rsp.node_id !== want.node_id) report_mismatch("node_id", rsp.node_id, want.node_id);
        if (rsp.kept_count !== want.kept_count)
          report_mismatch("kept_count", rsp.kept_count, want.kept_count);
        if (rsp.feedback_count !== want.feedback_count)
          report_mismatch("feedback_count", rsp.feedback_count, want.feedback_count);
      end
    end
  end

  int burst_left;

  // Send one item: hold start and req until the accepting edge. Leave start
  // up afterwards so the next item of a burst can follow; drop it in gaps.
  task automatic send_item(logic [2:0] op, int f, int t, int idx);
    req_t it;
    rsp_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3, 0) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
    burst_left--;
    it.req_type = op; it.from_node = 10'(f); it.to_node = 10'(t); it.index = 10'(idx);
    start <= 1'b1;
    req   <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = predict_rsp(it);
    expected_rsp.insert(expected_rsp.size(), pred);
    n_items++;
  endtask

  // Drain outstanding results, then write the node count while idle.
  task automatic set_nodes(int v);
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    node_count_we    <= 1'b1;
    node_count_wdata <= 11'(v);
    @(posedge clk);
    node_count_we    <= 1'b0;
    m_nodes = v;
    @(posedge clk);
  endtask

  // Build a random graph on n nodes; mostly well formed, some bad nodes.
  task automatic load_graph(int n, int edges);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(9, 0) == 0) send_item(REQ_ADD, $urandom_range(1023, 0),
                                               $urandom_range(1023, 0), $urandom);
      else send_item(REQ_ADD, $urandom_range(n-1, 0), $urandom_range(n-1, 0), $urandom);
    end
  endtask

  task automatic read_back(int n);
    repeat ($urandom_range(((n > 16) ? 16 : n) + 3, 1)) begin
      send_item($urandom_range(1, 0) ? REQ_ORDER : REQ_FB, $urandom, $urandom,
                $urandom_range(n + 2, 0));
    end
  endtask

  task automatic test_directed();
    // Reads before any run hit empty lists.
    send_item(REQ_ORDER, 0, 0, 0);
    send_item(REQ_FB, 0, 0, 1023);
    send_item(REQ_ADD, 1023, 1023, 0);
    send_item(3'd5, 1023, 1023, 1023);
    send_item(3'd7, 0, 0, 0);
    set_nodes(4);
    // Cycle 0->1->2->0, a tail 2->3, and two out-of-range edges on node 4.
    send_item(REQ_ADD, 0, 1, 0);
    send_item(REQ_ADD, 1, 2, 0);
    send_item(REQ_ADD, 2, 0, 0);
    send_item(REQ_ADD, 2, 3, 0);
    send_item(REQ_ADD, 4, 0, 0);
    send_item(REQ_ADD, 0, 4, 0);
    send_item(REQ_RUN, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_item(REQ_ORDER, 0, 0, i);
    send_item(REQ_FB, 0, 0, 0);
    send_item(REQ_FB, 0, 0, 1);
    // Lowered count ignores edges into dropped nodes.
    set_nodes(2);
    send_item(REQ_RUN, 0, 0, 0);
    send_item(REQ_ORDER, 0, 0, 1);
    // Zero nodes gives an empty run; clear keeps last lists.
    set_nodes(0);
    send_item(REQ_RUN, 0, 0, 0);
    send_item(REQ_CLEAR, 0, 0, 0);
    send_item(REQ_ORDER, 0, 0, 0);
  endtask

  // Node count above the node limit: every node id is in range.
  task automatic test_wide_count();
    set_nodes(2047);
    send_item(REQ_CLEAR, 0, 0, 0);
    for (int i = 0; i < 40; i++)
      send_item(REQ_ADD, $urandom_range(1023, 0), $urandom_range(1023, 0), 0);
    send_item(REQ_RUN, 0, 0, 0);
    send_item(REQ_ORDER, 0, 0, 1023);
    send_item(REQ_FB, 0, 0, 0);
    send_item(REQ_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random_graphs();
    int n;
    while (n_items < 600) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(1024, 1) : $urandom_range(12, 1);
      set_nodes(n);
      send_item(REQ_CLEAR, 0, 0, 0);
      load_graph(n, (n > 16) ? $urandom_range(40, 0) : $urandom_range(2 * n + 2, 0));
      if ($urandom_range(4, 0) == 0) set_nodes($urandom_range(n, 1));
      send_item(REQ_RUN, 0, 0, 0);
      read_back(n);
      if ($urandom_range(5, 0) == 0)
        send_item(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    errors = 0; n_items = 0; n_results = 0; n_runs = 0; cycles = 0; burst_left = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    node_count_we = 1'b0;
    node_count_wdata = '0;
    m_nodes = 1; m_kept = 0; m_fbcnt = 0;
    for (int i = 0; i < EdgeMax; i++) begin m_target[i] = 0; m_next[i] = 0; end
    for (int i = 0; i < NodeMax; i++) begin m_order[i] = 0; m_rank[i] = 0; m_fbl[i] = 0; end
    model_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_wide_count();
    test_random_graphs();

    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d results, %0d sort runs", n_items, n_results, n_runs);
    if (errors == 0 && expected_rsp.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
